@@ sv/nfps_pkg.sv @@
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared types and constants of the NAND flash page store: action and status
// codes, register indexes, the queued command and the back end states.
// ----------------------------------------------------------------------------
package nfps_pkg;

    localparam int DEF_MAX_BANKS  = 4;
    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_MAX_PAGES  = 16;

    localparam int DATA_W  = 256;
    localparam int SPARE_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_PROG  = 2'd1;
    localparam logic [1:0] ACT_ERASE = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BADADDR   = 3'd1;
    localparam logic [2:0] STS_OVERWRITE = 3'd2;
    localparam logic [2:0] STS_ORDER     = 3'd3;
    localparam logic [2:0] STS_EMPTY     = 3'd4;

    localparam logic [1:0] CFG_BANK_COUNT  = 2'd0;
    localparam logic [1:0] CFG_BLOCK_COUNT = 2'd1;
    localparam logic [1:0] CFG_PAGE_COUNT  = 2'd2;

    localparam logic [2:0] RST_BANK_COUNT  = 3'd4;
    localparam logic [4:0] RST_BLOCK_COUNT = 5'd16;
    localparam logic [4:0] RST_PAGE_COUNT  = 5'd16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_PROG,
        CMD_ERASE,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [1:0]           bank;
        logic [3:0]           block;
        logic [3:0]           page;
        logic [DATA_W-1:0]    data;
        logic [SPARE_W-1:0]   spare;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_EXEC
    } st_t;

endpackage

@@ sv/nfps_front.sv @@
// ----------------------------------------------------------------------------
// nfps_front
// Configuration registers and command classification. Checks the address
// against the configured sizes and hands a classified command to the queue.
// ----------------------------------------------------------------------------
module nfps_front
    import nfps_pkg::*;
#(
    parameter int MAX_BANKS  = DEF_MAX_BANKS,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int MAX_PAGES  = DEF_MAX_PAGES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               push,
    input  logic [1:0]         action,
    input  logic [1:0]         bank,
    input  logic [3:0]         block,
    input  logic [3:0]         page,
    input  logic [DATA_W-1:0]  wdata,
    input  logic [SPARE_W-1:0] wspare,
    input  logic               q_full,
    input  logic               clearing,
    output logic               full,
    output logic               q_push,
    output cmd_t               q_wdata
);

    logic [2:0] bank_count_reg;
    logic [4:0] block_count_reg;
    logic [4:0] page_count_reg;
    logic       blk_ok;
    logic       page_ok;
    cmd_kind_t  kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_count_reg  <= RST_BANK_COUNT;
            block_count_reg <= RST_BLOCK_COUNT;
            page_count_reg  <= RST_PAGE_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BANK_COUNT:  bank_count_reg  <= cfg_wdata[2:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_wdata;
                CFG_PAGE_COUNT:  page_count_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign blk_ok = (32'(bank) < 32'(bank_count_reg)) && (32'(bank) < MAX_BANKS)
                 && (32'(block) < 32'(block_count_reg)) && (32'(block) < MAX_BLOCKS);
    assign page_ok = blk_ok && (32'(page) < 32'(page_count_reg))
                  && (32'(page) < MAX_PAGES);

    always_comb
    begin
        case (action)
            ACT_READ:  kind = page_ok ? CMD_READ  : CMD_BAD;
            ACT_PROG:  kind = page_ok ? CMD_PROG  : CMD_BAD;
            ACT_ERASE: kind = blk_ok  ? CMD_ERASE : CMD_BAD;
            default:   kind = CMD_BAD;
        endcase
    end

    assign full          = q_full || clearing;
    assign q_push        = push && !full;
    assign q_wdata.kind  = kind;
    assign q_wdata.bank  = bank;
    assign q_wdata.block = block;
    assign q_wdata.page  = page;
    assign q_wdata.data  = wdata;
    assign q_wdata.spare = wspare;

endmodule

@@ sv/nfps_queue.sv @@
// ----------------------------------------------------------------------------
// nfps_queue
// Short command queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module nfps_queue
    import nfps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_push,
    input  cmd_t q_wdata,
    input  logic q_pop,
    output cmd_t q_rdata,
    output logic q_full,
    output logic q_empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule

@@ sv/nfps_back.sv @@
// ----------------------------------------------------------------------------
// nfps_back
// Executes queued commands against the written-mark and page memories and
// holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
module nfps_back
    import nfps_pkg::*;
#(
    parameter int MAX_BANKS  = DEF_MAX_BANKS,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int MAX_PAGES  = DEF_MAX_PAGES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               q_rdata,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               clearing,
    input  logic               pop,
    output logic               empty,
    output logic [2:0]         status,
    output logic [DATA_W-1:0]  rdata,
    output logic [SPARE_W-1:0] rspare
);

    localparam int ROWS    = MAX_BANKS * MAX_BLOCKS;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOTS   = ROWS * MAX_PAGES;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAGE_AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int WORD_W  = DATA_W + SPARE_W;

    logic [MAX_PAGES-1:0] marks_mem [ROWS];
    logic [WORD_W-1:0]    pages_mem [SLOTS];

    st_t                  state_reg;
    st_t                  state_next;
    logic [ROW_W-1:0]     clr_cnt_reg;
    logic [ROW_W-1:0]     clr_cnt_next;
    cmd_t                 cmd_reg;
    logic [MAX_PAGES-1:0] mark_rd_reg;
    logic [WORD_W-1:0]    page_rd_reg;
    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic [SPARE_W-1:0]   rspare_reg;

    logic                 clr_done;
    logic                 load_out;
    logic                 mark_we;
    logic [ROW_W-1:0]     mark_waddr;
    logic [MAX_PAGES-1:0] mark_wdata;
    logic                 page_we;
    logic [ROW_W-1:0]     cmd_row;
    logic [SLOT_W-1:0]    cmd_slot;
    logic [PAGE_AW-1:0]   page_idx;
    logic                 hit;
    logic                 prev_hit;
    logic [2:0]           exec_status;
    logic                 exec_rd_ok;

    function automatic logic [ROW_W-1:0] row_of(input cmd_t c);
        return ROW_W'(ROW_W'(c.bank) * ROW_W'(MAX_BLOCKS) + ROW_W'(c.block));
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input cmd_t c);
        return SLOT_W'(SLOT_W'(row_of(c)) * SLOT_W'(MAX_PAGES) + SLOT_W'(c.page));
    endfunction

    assign clr_done = (clr_cnt_reg == ROW_W'(ROWS - 1));
    assign cmd_row  = row_of(cmd_reg);
    assign cmd_slot = slot_of(cmd_reg);
    assign page_idx = PAGE_AW'(cmd_reg.page);
    assign hit      = mark_rd_reg[page_idx];
    assign prev_hit = mark_rd_reg[page_idx - 1'b1];

    always_comb
    begin
        exec_rd_ok = 1'b0;
        case (cmd_reg.kind)
            CMD_READ:
            begin
                exec_status = hit ? STS_OK : STS_EMPTY;
                exec_rd_ok  = hit;
            end
            CMD_PROG:
            begin
                if (hit)
                begin
                    exec_status = STS_OVERWRITE;
                end
                else if ((cmd_reg.page != 4'd0) && !prev_hit)
                begin
                    exec_status = STS_ORDER;
                end
                else
                begin
                    exec_status = STS_OK;
                end
            end
            CMD_ERASE: exec_status = mark_rd_reg[0] ? STS_OK : STS_EMPTY;
            default:   exec_status = STS_BADADDR;
        endcase
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (!q_empty)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = ST_FETCH;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop      = 1'b0;
        load_out   = 1'b0;
        mark_we    = 1'b0;
        mark_waddr = cmd_row;
        mark_wdata = '0;
        page_we    = 1'b0;
        clearing   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing   = 1'b1;
                mark_we    = 1'b1;
                mark_waddr = clr_cnt_reg;
            end
            ST_FETCH:
            begin
                q_pop = !q_empty;
            end
            ST_EXEC:
            begin
                load_out = !out_valid_reg || pop;
                if (load_out && (exec_status == STS_OK))
                begin
                    if (cmd_reg.kind == CMD_PROG)
                    begin
                        mark_we    = 1'b1;
                        mark_wdata = mark_rd_reg | (MAX_PAGES'(1) << page_idx);
                        page_we    = 1'b1;
                    end
                    else if (cmd_reg.kind == CMD_ERASE)
                    begin
                        mark_we = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg     <= q_rdata;
            mark_rd_reg <= marks_mem[row_of(q_rdata)];
            page_rd_reg <= pages_mem[slot_of(q_rdata)];
        end
        if (load_out)
        begin
            status_reg <= exec_status;
            rdata_reg  <= exec_rd_ok ? page_rd_reg[WORD_W-1:SPARE_W] : '0;
            rspare_reg <= exec_rd_ok ? page_rd_reg[SPARE_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            marks_mem[mark_waddr] <= mark_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            pages_mem[cmd_slot] <= {cmd_reg.data, cmd_reg.spare};
        end
    end

    assign empty  = !out_valid_reg;
    assign status = status_reg;
    assign rdata  = rdata_reg;
    assign rspare = rspare_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("command taken during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) && !q_empty |=> (state_reg == ST_EXEC))
        else $error("fetch not followed by execute");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || pop))
        else $error("result register overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != STS_OK) |-> (rdata_reg == '0) && (rspare_reg == '0))
        else $error("read data on failed transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        page_we |-> mark_we && (cmd_reg.kind == CMD_PROG))
        else $error("page write without mark update");

endmodule

@@ sv/nand_flash_page_store_unit.sv @@
// ----------------------------------------------------------------------------
// nand_flash_page_store_unit
// NAND flash page store: read, program and block erase over banks, blocks
// and pages of 32 data bytes and 4 spare bytes.
// ----------------------------------------------------------------------------
// Each accepted transaction yields one result transaction. The back end
// reads the block's written-mark word and the page memory in its fetch
// state and updates them in its execute state, which waits while the
// one-entry output register holds a result not yet taken. After reset
// the mark memory is cleared one block row per cycle, over all
// MAX_BANKS*MAX_BLOCKS rows (64 by default), and full stays high until
// that pass is done. Configuration writes are taken at any time, but only
// while no transaction is in flight do they give defined results.
module nand_flash_page_store_unit
    import nfps_pkg::*;
#(
    parameter int MAX_BANKS  = DEF_MAX_BANKS,
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int MAX_PAGES  = DEF_MAX_PAGES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic [1:0]         bank,
    input  logic [3:0]         block,
    input  logic [3:0]         page,
    input  logic [63:0]        wdata0,
    input  logic [63:0]        wdata1,
    input  logic [63:0]        wdata2,
    input  logic [63:0]        wdata3,
    input  logic [SPARE_W-1:0] wspare,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         status,
    output logic [63:0]        rdata0,
    output logic [63:0]        rdata1,
    output logic [63:0]        rdata2,
    output logic [63:0]        rdata3,
    output logic [SPARE_W-1:0] rspare
);

    logic              q_push;
    cmd_t              q_wdata;
    logic              q_pop;
    cmd_t              q_rdata;
    logic              q_full;
    logic              q_empty;
    logic              clearing;
    logic [DATA_W-1:0] rdata;

    nfps_front #(
        .MAX_BANKS  (MAX_BANKS),
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_PAGES  (MAX_PAGES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .action    (action),
        .bank      (bank),
        .block     (block),
        .page      (page),
        .wdata     ({wdata3, wdata2, wdata1, wdata0}),
        .wspare    (wspare),
        .q_full    (q_full),
        .clearing  (clearing),
        .full      (full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    nfps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    nfps_back #(
        .MAX_BANKS  (MAX_BANKS),
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_PAGES  (MAX_PAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_rdata  (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .status   (status),
        .rdata    (rdata),
        .rspare   (rspare)
    );

    assign rdata0 = rdata[63:0];
    assign rdata1 = rdata[127:64];
    assign rdata2 = rdata[191:128];
    assign rdata3 = rdata[255:192];

endmodule

@@ tb/sv/tb_nand_flash_page_store_unit.sv @@
// ----------------------------------------------------------------------------
// tb_nand_flash_page_store_unit
// Self-checking bench for the NAND flash page store. A directed table covers
// the status codes, field extremes and register limits. Random phases under
// several register settings follow, mostly ordered programs, reads and erases.
// Every result transaction is checked against a behavioral copy of the array,
// or against a fixed expected status and zero data for typed directed rows.
module tb_nand_flash_page_store_unit;
    import nfps_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE = 8;
    localparam int NUM_PHASES = 9;

    typedef struct {
        logic [1:0]   action;
        logic [1:0]   bank;
        logic [3:0]   block;
        logic [3:0]   page;
        logic [255:0] data;
        logic [31:0]  spare;
    } flash_op_t;

    typedef struct {
        logic [2:0]   status;
        logic [255:0] data;
        logic [31:0]  spare;
    } flash_reply_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] reg_idx;
        logic [4:0] reg_val;
        flash_op_t  op;
        bit         typed;
        logic [2:0] want_status;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               push;
    logic               full;
    logic [1:0]         action;
    logic [1:0]         bank;
    logic [3:0]         block;
    logic [3:0]         page;
    logic [63:0]        wdata0;
    logic [63:0]        wdata1;
    logic [63:0]        wdata2;
    logic [63:0]        wdata3;
    logic [SPARE_W-1:0] wspare;
    logic               empty;
    logic               pop;
    logic [2:0]         status;
    logic [63:0]        rdata0;
    logic [63:0]        rdata1;
    logic [63:0]        rdata2;
    logic [63:0]        rdata3;
    logic [SPARE_W-1:0] rspare;

    nand_flash_page_store_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .push(push), .full(full),
        .action(action), .bank(bank), .block(block), .page(page),
        .wdata0(wdata0), .wdata1(wdata1), .wdata2(wdata2), .wdata3(wdata3),
        .wspare(wspare),
        .empty(empty), .pop(pop),
        .status(status),
        .rdata0(rdata0), .rdata1(rdata1), .rdata2(rdata2), .rdata3(rdata3),
        .rspare(rspare)
    );

    always #2 clk = ~clk;

    // array image
    bit           page_written [0:1023];
    logic [255:0] page_data    [0:1023];
    logic [31:0]  page_spare   [0:1023];
    int           reg_banks;
    int           reg_blocks;
    int           reg_pages;

    flash_reply_t pending_replies[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycle_count = 0;
    bit           steady = 1'b0;

    function automatic int clamp(int v, int lim);
        return (v < lim) ? v : lim;
    endfunction

    function automatic flash_reply_t apply_access(flash_op_t o);
        flash_reply_t r;
        bit           blk_ok;
        bit           pg_ok;
        logic [9:0]   at;
        r.status = STS_OK;
        r.data   = '0;
        r.spare  = '0;
        blk_ok = (o.bank < clamp(reg_banks, DEF_MAX_BANKS)) &&
                 (o.block < clamp(reg_blocks, DEF_MAX_BLOCKS));
        pg_ok  = blk_ok && (o.page < clamp(reg_pages, DEF_MAX_PAGES));
        at     = {o.bank, o.block, o.page};
        case (o.action)
            ACT_READ:
            begin
                if (!pg_ok)
                    r.status = STS_BADADDR;
                else if (!page_written[at])
                    r.status = STS_EMPTY;
                else
                begin
                    r.data  = page_data[at];
                    r.spare = page_spare[at];
                end
            end
            ACT_PROG:
            begin
                if (!pg_ok)
                    r.status = STS_BADADDR;
                else if (page_written[at])
                    r.status = STS_OVERWRITE;
                else if (o.page != 4'd0 && !page_written[at - 10'd1])
                    r.status = STS_ORDER;
                else
                begin
                    page_data[at]    = o.data;
                    page_spare[at]   = o.spare;
                    page_written[at] = 1'b1;
                end
            end
            ACT_ERASE:
            begin
                if (!blk_ok)
                    r.status = STS_BADADDR;
                else if (!page_written[{o.bank, o.block, 4'd0}])
                    r.status = STS_EMPTY;
                else
                    for (int k = 0; k < DEF_MAX_PAGES; k++)
                        page_written[{o.bank, o.block, 4'(k)}] = 1'b0;
            end
            default: r.status = STS_BADADDR;
        endcase
        return r;
    endfunction

    // mostly well-formed traffic: in-range addresses, next free page for
    // programs, written pages for reads; the rest is noise
    function automatic flash_op_t pick_op();
        flash_op_t o;
        int        nb;
        int        nk;
        int        np;
        int        filled;
        int        r;
        nb = clamp(reg_banks, DEF_MAX_BANKS);
        nk = clamp(reg_blocks, DEF_MAX_BLOCKS);
        np = clamp(reg_pages, DEF_MAX_PAGES);
        o.data  = {$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
        o.spare = $urandom;
        o.page  = 4'($urandom);
        if (nb > 0 && nk > 0 && $urandom_range(99) < 85)
        begin
            o.bank = 2'($urandom_range(nb - 1));
            if ($urandom_range(1) == 0)
                o.block = 4'($urandom_range(clamp(nk, 2) - 1));
            else
                o.block = 4'($urandom_range(nk - 1));
        end
        else
        begin
            o.bank  = 2'($urandom);
            o.block = 4'($urandom);
        end
        filled = 0;
        while (filled < DEF_MAX_PAGES && page_written[{o.bank, o.block, 4'(filled)}])
            filled++;
        r = $urandom_range(99);
        if (r < 45)
        begin
            o.action = ACT_PROG;
            if (filled < np && $urandom_range(3) != 0)
                o.page = 4'(filled);
        end
        else if (r < 80)
        begin
            o.action = ACT_READ;
            if (filled > 0 && $urandom_range(3) != 0)
                o.page = 4'($urandom_range(filled - 1));
        end
        else if (r < 93)
            o.action = ACT_ERASE;
        else
            o.action = ACT_UNUSED;
        return o;
    endfunction

    task automatic flag_mismatch(string what, logic [255:0] got, logic [255:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    // leaves push high; the caller lowers it when idling
    task automatic offer(flash_op_t o, bit typed, logic [2:0] want_status);
        flash_reply_t r;
        push   <= 1'b1;
        action <= o.action;
        bank   <= o.bank;
        block  <= o.block;
        page   <= o.page;
        wdata0 <= o.data[63:0];
        wdata1 <= o.data[127:64];
        wdata2 <= o.data[191:128];
        wdata3 <= o.data[255:192];
        wspare <= o.spare;
        @(posedge clk);
        while (full)
            @(posedge clk);
        r = apply_access(o);
        if (typed)
        begin
            r.status = want_status;
            r.data   = '0;
            r.spare  = '0;
        end
        pending_replies.push_back(r);
    endtask

    task automatic sender_gap();
        while (!steady && $urandom_range(99) < 33)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_BANK_COUNT:  reg_banks  = int'(val[2:0]);
            CFG_BLOCK_COUNT: reg_blocks = int'(val);
            CFG_PAGE_COUNT:  reg_pages  = int'(val);
            default: ;
        endcase
    endtask

    function automatic stim_row_t op_row(logic [1:0] a, logic [1:0] bk, logic [3:0] blk,
                                         logic [3:0] pg, logic [255:0] d, logic [31:0] s,
                                         bit typed, logic [2:0] st);
        stim_row_t row;
        row.is_cfg      = 1'b0;
        row.reg_idx     = CFG_BANK_COUNT;
        row.reg_val     = '0;
        row.op          = '{a, bk, blk, pg, d, s};
        row.typed       = typed;
        row.want_status = st;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [1:0] idx, logic [4:0] val);
        stim_row_t row;
        row         = op_row(ACT_READ, 2'd0, 4'd0, 4'd0, '0, '0, 1'b0, STS_OK);
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : result_side
        flash_reply_t want;
        int           hold_left;
        bit           hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_replies.size() == 0)
                    flag_mismatch("unexpected transaction, status", 256'(status), '0);
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", 256'(status), 256'(want.status));
                    if (rdata0 !== want.data[63:0])
                        flag_mismatch("rdata0", 256'(rdata0), 256'(want.data[63:0]));
                    if (rdata1 !== want.data[127:64])
                        flag_mismatch("rdata1", 256'(rdata1), 256'(want.data[127:64]));
                    if (rdata2 !== want.data[191:128])
                        flag_mismatch("rdata2", 256'(rdata2), 256'(want.data[191:128]));
                    if (rdata3 !== want.data[255:192])
                        flag_mismatch("rdata3", 256'(rdata3), 256'(want.data[255:192]));
                    if (rspare !== want.spare)
                        flag_mismatch("rspare", 256'(rspare), 256'(want.spare));
                end
                results_seen++;
            end
            if (!hold_done && results_seen == 300)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= steady || ($urandom_range(99) >= 33);
        end
    end

    initial
    begin : stimulus
        stim_row_t plan[$];
        int        phase_banks [NUM_PHASES] = '{4, 7, 1, 2, 3, 0, 4, 4, 4};
        int        phase_blocks[NUM_PHASES] = '{16, 31, 1, 5, 16, 16, 0, 16, 16};
        int        phase_pages [NUM_PHASES] = '{16, 31, 1, 3, 8, 16, 16, 0, 16};
        int        phase_items [NUM_PHASES] = '{200, 120, 60, 100, 120, 20, 20, 20, 190};
        logic [255:0] ones;
        logic [255:0] mixed;

        ones  = '1;
        mixed = {8{32'hA55A_C33C}};
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BANK_COUNT;
        cfg_wdata <= '0;
        push      <= 1'b0;
        action    <= ACT_READ;
        bank      <= '0;
        block     <= '0;
        page      <= '0;
        wdata0    <= '0;
        wdata1    <= '0;
        wdata2    <= '0;
        wdata3    <= '0;
        wspare    <= '0;
        for (int i = 0; i < 1024; i++)
            page_written[i] = 1'b0;
        reg_banks  = int'(RST_BANK_COUNT);
        reg_blocks = int'(RST_BLOCK_COUNT);
        reg_pages  = int'(RST_PAGE_COUNT);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh array, reset sizes
        plan.push_back(op_row(ACT_READ,   2'd0, 4'd0,  4'd0,  '0,    '0, 1'b1, STS_EMPTY));
        plan.push_back(op_row(ACT_ERASE,  2'd0, 4'd0,  4'd0,  '0,    '0, 1'b1, STS_EMPTY));
        plan.push_back(op_row(ACT_PROG,   2'd0, 4'd0,  4'd1,  ones,  '1, 1'b1, STS_ORDER));
        plan.push_back(op_row(ACT_PROG,   2'd0, 4'd0,  4'd0,  ones,  '1, 1'b1, STS_OK));
        plan.push_back(op_row(ACT_READ,   2'd0, 4'd0,  4'd0,  '0,    '0, 1'b0, STS_OK));
        plan.push_back(op_row(ACT_PROG,   2'd0, 4'd0,  4'd0,  '0,    '0, 1'b1, STS_OVERWRITE));
        plan.push_back(op_row(ACT_PROG,   2'd0, 4'd0,  4'd1,  '0,    '0, 1'b1, STS_OK));
        plan.push_back(op_row(ACT_READ,   2'd0, 4'd0,  4'd1,  ones,  '1, 1'b0, STS_OK));
        plan.push_back(op_row(ACT_PROG,   2'd3, 4'd15, 4'd0,  mixed, 32'h5AA5_3CC3,
                              1'b1, STS_OK));
        plan.push_back(op_row(ACT_PROG,   2'd3, 4'd15, 4'd15, ones,  '1, 1'b1, STS_ORDER));
        plan.push_back(op_row(ACT_READ,   2'd3, 4'd15, 4'd15, '0,    '0, 1'b1, STS_EMPTY));
        plan.push_back(op_row(ACT_UNUSED, 2'd3, 4'd15, 4'd0,  ones,  '1, 1'b1, STS_BADADDR));
        plan.push_back(op_row(ACT_READ,   2'd3, 4'd15, 4'd0,  '0,    '0, 1'b0, STS_OK));
        // page field does not matter for an erase
        plan.push_back(op_row(ACT_ERASE,  2'd3, 4'd15, 4'd9,  '0,    '0, 1'b1, STS_OK));
        plan.push_back(op_row(ACT_READ,   2'd3, 4'd15, 4'd0,  '0,    '0, 1'b1, STS_EMPTY));
        plan.push_back(op_row(ACT_ERASE,  2'd3, 4'd15, 4'd0,  '0,    '0, 1'b1, STS_EMPTY));
        plan.push_back(op_row(ACT_PROG,   2'd3, 4'd15, 4'd0,  ones,  '1, 1'b1, STS_OK));
        plan.push_back(op_row(ACT_READ,   2'd3, 4'd15, 4'd0,  '0,    '0, 1'b0, STS_OK));
        plan.push_back(cfg_row(CFG_BANK_COUNT, 5'd1));
        plan.push_back(op_row(ACT_READ,   2'd1, 4'd0,  4'd0,  '0,    '0, 1'b1, STS_BADADDR));
        plan.push_back(op_row(ACT_ERASE,  2'd3, 4'd15, 4'd0,  '0,    '0, 1'b1, STS_BADADDR));
        plan.push_back(cfg_row(CFG_PAGE_COUNT, 5'd0));
        plan.push_back(op_row(ACT_READ,   2'd0, 4'd0,  4'd0,  '0,    '0, 1'b1, STS_BADADDR));
        plan.push_back(op_row(ACT_ERASE,  2'd0, 4'd0,  4'd15, '0,    '0, 1'b1, STS_OK));
        plan.push_back(cfg_row(CFG_BLOCK_COUNT, 5'd0));
        plan.push_back(op_row(ACT_PROG,   2'd0, 4'd0,  4'd0,  ones,  '1, 1'b1, STS_BADADDR));
        plan.push_back(op_row(ACT_ERASE,  2'd0, 4'd0,  4'd0,  '0,    '0, 1'b1, STS_BADADDR));

        write_reg(CFG_BANK_COUNT, 5'(RST_BANK_COUNT));
        write_reg(CFG_BLOCK_COUNT, RST_BLOCK_COUNT);
        write_reg(CFG_PAGE_COUNT, RST_PAGE_COUNT);
        cfg_we <= 1'b0;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                cfg_we <= 1'b0;
            end
            else
            begin
                sender_gap();
                offer(plan[i].op, plan[i].typed, plan[i].want_status);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_reg(CFG_BANK_COUNT, 5'(phase_banks[p]));
            write_reg(CFG_BLOCK_COUNT, 5'(phase_blocks[p]));
            write_reg(CFG_PAGE_COUNT, 5'(phase_pages[p]));
            cfg_we <= 1'b0;
            steady = (p == 3);
            for (int n = 0; n < phase_items[p]; n++)
            begin
                sender_gap();
                offer(pick_op(), 1'b0, STS_OK);
            end
        end

        steady = 1'b0;
        drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
